[hdl/depth_pixel_deprojection_top_assert.svh]
// Assertion macros used by the depth pixel deprojection RTL.
`ifndef DEPTH_PIXEL_DEPROJECTION_TOP_ASSERT_SVH
`define DEPTH_PIXEL_DEPROJECTION_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The antecedent implies the consequent in the same cycle.
`define DPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define DPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DPD_ASSERT_IMPL(lbl, ante, cons, msg)
`define DPD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/dpd_pkg.sv]
// Types and constants of the depth pixel deprojection block.
package dpd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned NumRows  = 3;
  localparam int unsigned NumStages = 6;

  // Camera coordinate: 44 magnitude bits plus sign, Q.16 millimetres.
  localparam int unsigned CamW   = 45;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned AccW   = 64;
  localparam int unsigned CamShift   = 20;
  localparam int unsigned DepthShift = 16;
  localparam int unsigned WorldShift = 30;

  localparam logic [ProdW-1:0] CamRound   = ProdW'(1) << (CamShift - 1);
  localparam logic [AccW-1:0]  WorldRound = AccW'(1) << (WorldShift - 1);

  localparam logic signed [31:0] WorldMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] WorldMin = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRecipX  = 3'd0,
    CfgRecipY  = 3'd1,
    CfgCenterX = 3'd2,
    CfgCenterY = 3'd3,
    CfgRow0    = 3'd4,
    CfgRow1    = 3'd5,
    CfgRow2    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] pixel_u;
    logic [15:0] pixel_v;
    logic [15:0] depth_mm;
  } dpd_in_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic               saturated;
  } dpd_out_t;

endpackage

[hdl/depth_pixel_deprojection_top.sv]
// Depth pixel deprojection: pinhole back-projection followed by a 3x4 rigid transform.
// Throughput: one transaction per cycle while the output is ready; six register
// stages, each with its own valid bit.
// A stalled output only holds the stages that are full: empty stages keep filling.
// Reset (rst_ni low, asynchronous) empties every stage and clears all configuration
// registers to zero, after which every result is zero until the transform is loaded.
`include "depth_pixel_deprojection_top_assert.svh"

module depth_pixel_deprojection_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [dpd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [dpd_pkg::CfgDataW-1:0]        cfg_data_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dpd_pkg::dpd_in_t                    in_data_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dpd_pkg::dpd_out_t                   out_data_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes arrive only while the pipeline is empty: the user
  // must keep to this, the block itself does not enforce it. Every stage reads these directly.
  // ---------------------------------------------------------------------------
  logic [31:0] recip_x_q, recip_y_q;
  logic [15:0] center_x_q, center_y_q;
  logic [63:0] trow_q [dpd_pkg::NumRows];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_x_q  <= '0;
      recip_y_q  <= '0;
      center_x_q <= '0;
      center_y_q <= '0;
      for (int r = 0; r < dpd_pkg::NumRows; r++) begin
        trow_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      // Indexes beyond the register list are ignored.
      unique case (dpd_pkg::cfg_idx_e'(cfg_index_i))
        dpd_pkg::CfgRecipX:  recip_x_q  <= cfg_data_i[31:0];
        dpd_pkg::CfgRecipY:  recip_y_q  <= cfg_data_i[31:0];
        dpd_pkg::CfgCenterX: center_x_q <= cfg_data_i[15:0];
        dpd_pkg::CfgCenterY: center_y_q <= cfg_data_i[15:0];
        dpd_pkg::CfgRow0:    trow_q[0]  <= cfg_data_i;
        dpd_pkg::CfgRow1:    trow_q[1]  <= cfg_data_i;
        dpd_pkg::CfgRow2:    trow_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. A stage may load when it is empty or when the stage after it
  // loads in the same cycle, so bubbles collapse and a stall at the output only
  // holds the stages that actually carry a transaction.
  // ---------------------------------------------------------------------------
  logic [dpd_pkg::NumStages-1:0] v_q, v_d, en;

  always_comb begin
    en[dpd_pkg::NumStages-1] = !v_q[dpd_pkg::NumStages-1] || out_ready_i;
    for (int k = dpd_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < dpd_pkg::NumStages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[dpd_pkg::NumStages-1];

  // ---------------------------------------------------------------------------
  // Stage 1: offset from the principal point, its magnitude and sign, and the
  // 16 by 16 product of that magnitude with the depth.
  // ---------------------------------------------------------------------------
  logic signed [16:0] du_x, du_y;
  logic [15:0] mag_x, mag_y;
  logic        s1_neg_x_d, s1_neg_y_d, s1_neg_x_q, s1_neg_y_q;
  logic [31:0] s1_pd_x_d, s1_pd_y_d, s1_pd_x_q, s1_pd_y_q;
  logic [15:0] s1_depth_q;

  always_comb begin
    du_x = $signed({1'b0, in_data_i.pixel_u}) - $signed({1'b0, center_x_q});
    du_y = $signed({1'b0, in_data_i.pixel_v}) - $signed({1'b0, center_y_q});
    s1_neg_x_d = du_x[16];
    s1_neg_y_d = du_y[16];
    mag_x = du_x[16] ? 16'(-du_x) : du_x[15:0];
    mag_y = du_y[16] ? 16'(-du_y) : du_y[15:0];
    s1_pd_x_d = 32'(mag_x) * 32'(in_data_i.depth_mm);
    s1_pd_y_d = 32'(mag_y) * 32'(in_data_i.depth_mm);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_neg_x_q <= s1_neg_x_d;
      s1_neg_y_q <= s1_neg_y_d;
      s1_pd_x_q  <= s1_pd_x_d;
      s1_pd_y_q  <= s1_pd_y_d;
      s1_depth_q <= in_data_i.depth_mm;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: multiplication by the reciprocal focal length, 32 by 32 bits. The
  // full product cannot exceed 64 bits for any register setting.
  // ---------------------------------------------------------------------------
  logic [dpd_pkg::ProdW-1:0] s2_prod_x_d, s2_prod_y_d, s2_prod_x_q, s2_prod_y_q;
  logic        s2_neg_x_q, s2_neg_y_q;
  logic [15:0] s2_depth_q;

  always_comb begin
    s2_prod_x_d = dpd_pkg::ProdW'(s1_pd_x_q) * dpd_pkg::ProdW'(recip_x_q);
    s2_prod_y_d = dpd_pkg::ProdW'(s1_pd_y_q) * dpd_pkg::ProdW'(recip_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_prod_x_q <= s2_prod_x_d;
      s2_prod_y_q <= s2_prod_y_d;
      s2_neg_x_q  <= s1_neg_x_q;
      s2_neg_y_q  <= s1_neg_y_q;
      s2_depth_q  <= s1_depth_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: round the magnitude to Q.16 millimetres and restore the sign, which
  // gives rounding half away from zero.
  // ---------------------------------------------------------------------------
  localparam int unsigned QW = dpd_pkg::ProdW - dpd_pkg::CamShift;

  logic [dpd_pkg::ProdW-1:0]        rnd_x, rnd_y;
  logic [QW-1:0]                    q_x, q_y;
  logic signed [dpd_pkg::CamW-1:0]  s3_cam_x_d, s3_cam_y_d, s3_cam_x_q, s3_cam_y_q;
  logic [15:0]                      s3_depth_q;

  always_comb begin
    rnd_x = s2_prod_x_q + dpd_pkg::CamRound;
    rnd_y = s2_prod_y_q + dpd_pkg::CamRound;
    q_x   = rnd_x[dpd_pkg::ProdW-1:dpd_pkg::CamShift];
    q_y   = rnd_y[dpd_pkg::ProdW-1:dpd_pkg::CamShift];
    s3_cam_x_d = s2_neg_x_q ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    s3_cam_y_d = s2_neg_y_q ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_cam_x_q <= s3_cam_x_d;
      s3_cam_y_q <= s3_cam_y_d;
      s3_depth_q <= s2_depth_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: the rotation products, one row of the transform per lane. The z
  // term is taken against the bare depth; its Q.16 weight is a shift later on.
  // ---------------------------------------------------------------------------
  localparam int unsigned PxyW = 16 + dpd_pkg::CamW;
  localparam int unsigned PzW  = 16 + 17;

  logic signed [PxyW-1:0] s4_p0_d [dpd_pkg::NumRows];
  logic signed [PxyW-1:0] s4_p1_d [dpd_pkg::NumRows];
  logic signed [PzW-1:0]  s4_p2_d [dpd_pkg::NumRows];
  logic signed [PxyW-1:0] s4_p0_q [dpd_pkg::NumRows];
  logic signed [PxyW-1:0] s4_p1_q [dpd_pkg::NumRows];
  logic signed [PzW-1:0]  s4_p2_q [dpd_pkg::NumRows];
  logic signed [15:0]     s4_t_q  [dpd_pkg::NumRows];

  always_comb begin
    for (int r = 0; r < dpd_pkg::NumRows; r++) begin
      s4_p0_d[r] = PxyW'($signed(trow_q[r][15:0])) * PxyW'(s3_cam_x_q);
      s4_p1_d[r] = PxyW'($signed(trow_q[r][31:16])) * PxyW'(s3_cam_y_q);
      s4_p2_d[r] = PzW'($signed(trow_q[r][47:32])) * $signed({17'd0, s3_depth_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int r = 0; r < dpd_pkg::NumRows; r++) begin
        s4_p0_q[r] <= s4_p0_d[r];
        s4_p1_q[r] <= s4_p1_d[r];
        s4_p2_q[r] <= s4_p2_d[r];
        s4_t_q[r]  <= $signed(trow_q[r][63:48]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: the Q.30 accumulator with the translation and the half-unit
  // rounding offset already added in. It is exact in 64 bits.
  // ---------------------------------------------------------------------------
  logic signed [dpd_pkg::AccW-1:0] s5_acc_d [dpd_pkg::NumRows];
  logic signed [dpd_pkg::AccW-1:0] s5_acc_q [dpd_pkg::NumRows];

  always_comb begin
    for (int r = 0; r < dpd_pkg::NumRows; r++) begin
      s5_acc_d[r] = dpd_pkg::AccW'(s4_p0_q[r])
                  + dpd_pkg::AccW'(s4_p1_q[r])
                  + (dpd_pkg::AccW'(s4_p2_q[r]) <<< dpd_pkg::DepthShift)
                  + (dpd_pkg::AccW'(s4_t_q[r]) <<< dpd_pkg::WorldShift)
                  + $signed(dpd_pkg::WorldRound);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int r = 0; r < dpd_pkg::NumRows; r++) begin
        s5_acc_q[r] <= s5_acc_d[r];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: dropping the 30 fraction bits of a two's complement value floors
  // it; anything outside 32 bits is clipped and flagged. This stage is the
  // output register.
  // ---------------------------------------------------------------------------
  localparam int unsigned WideW = dpd_pkg::AccW - dpd_pkg::WorldShift;

  logic [WideW-1:0]   wide   [dpd_pkg::NumRows];
  logic signed [31:0] world  [dpd_pkg::NumRows];
  logic [dpd_pkg::NumRows-1:0] clip;
  dpd_pkg::dpd_out_t  s6_out_d, s6_out_q;

  always_comb begin
    for (int r = 0; r < dpd_pkg::NumRows; r++) begin
      wide[r] = s5_acc_q[r][dpd_pkg::AccW-1:dpd_pkg::WorldShift];
      // In range when every bit from 31 upwards equals the sign bit.
      clip[r] = !((&wide[r][WideW-1:31]) || !(|wide[r][WideW-1:31]));
      if (!clip[r]) begin
        world[r] = $signed(wide[r][31:0]);
      end else if (wide[r][WideW-1]) begin
        world[r] = dpd_pkg::WorldMin;
      end else begin
        world[r] = dpd_pkg::WorldMax;
      end
    end
    s6_out_d.world_x   = world[0];
    s6_out_d.world_y   = world[1];
    s6_out_d.world_z   = world[2];
    s6_out_d.saturated = |clip;
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_out_q <= s6_out_d;
    end
  end

  assign out_data_o = s6_out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The input is held back only when every stage carries a transaction.
  `DPD_ASSERT_IMPL(a_ready_only_when_full, !in_ready_o, &v_q, "input stalled with a free stage")
  // A transaction in stage five moves to the output whenever the output stage frees up.
  `DPD_ASSERT_NEXT(a_stage5_advances, v_q[4] && en[5], out_valid_o, "transaction lost before output")
  // A clip flag always comes with a coordinate that sits on a 32-bit limit.
  `DPD_ASSERT_IMPL(a_sat_on_limit, out_valid_o && out_data_o.saturated,
    (out_data_o.world_x == dpd_pkg::WorldMax) || (out_data_o.world_x == dpd_pkg::WorldMin) ||
    (out_data_o.world_y == dpd_pkg::WorldMax) || (out_data_o.world_y == dpd_pkg::WorldMin) ||
    (out_data_o.world_z == dpd_pkg::WorldMax) || (out_data_o.world_z == dpd_pkg::WorldMin),
    "saturation flag without a clipped coordinate")

endmodule
